>>> src/rdp_pkg.sv
// shared types, constants and helpers for the timestamp parser
`default_nettype none
package rdp_pkg;

    localparam int CharW   = 8;
    localparam int MillisW = 64;
    localparam int UtcW    = 49;
    localparam int StateW  = 2;
    localparam int QueueDepth = 2;

    localparam logic [1:0] DL_UNKNOWN = 2'd0;
    localparam logic [1:0] DL_LIVE    = 2'd1;
    localparam logic [1:0] DL_EXPIRED = 2'd2;

    localparam logic [2:0] PH_FIXED     = 3'd0;
    localparam logic [2:0] PH_AFTER_SEC = 3'd1;
    localparam logic [2:0] PH_FRAC      = 3'd2;
    localparam logic [2:0] PH_OFFSET    = 3'd3;
    localparam logic [2:0] PH_DONE      = 3'd4;

    // one parsed string, handed from the front to the back end
    typedef struct packed {
        logic                      ok;
        logic [13:0]               year;
        logic [3:0]                month;
        logic [4:0]                day;
        logic [4:0]                hour;
        logic [5:0]                minute;
        logic [5:0]                second;
        logic [9:0]                frac;
        logic                      zone_neg;
        logic [4:0]                zone_hour;
        logic [5:0]                zone_minute;
        logic signed [MillisW-1:0] now;
    } rdp_job_t;

    function automatic logic [4:0] month_len(input logic [13:0] y, input logic [3:0] m);
        logic [26:0] prod;
        logic [7:0]  cent_q;
        logic        cent;
        logic        leap;
        begin
            // y / 100 by reciprocal multiplication, exact for any 14-bit year
            prod   = 27'(y) * 27'd5243;
            cent_q = prod[26:19];
            cent   = (y == 14'(cent_q) * 14'd100);
            leap   = (y[1:0] == 2'd0) && (!cent || cent_q[1:0] == 2'd0);
            case (m)
                4'd2: month_len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
                default: month_len = 5'd31;
            endcase
        end
    endfunction

endpackage
`default_nettype wire

>>> src/rdp_front.sv
// character front end: layout and range checks, field accumulation
`default_nettype none
module rdp_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [rdp_pkg::CharW-1:0]     text_char,
    input  wire logic                          last_char,
    input  wire logic signed [rdp_pkg::MillisW-1:0] now_millis,
    output logic                               job_valid,
    output rdp_pkg::rdp_job_t                  job,
    input  wire logic                          job_full
);
    import rdp_pkg::*;

    logic [4:0]  pos_reg, pos_next;
    logic [2:0]  phase_reg, phase_next;
    logic        err_reg, err_next;
    logic [13:0] year_reg, year_next;
    logic [3:0]  mon_reg, mon_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hr_reg, hr_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [9:0]  frac_reg, frac_next;
    logic [1:0]  fd_reg, fd_next;
    logic        zn_reg, zn_next;
    logic [4:0]  zh_reg, zh_next;
    logic [5:0]  zm_reg, zm_next;

    logic       take;
    logic       dig;
    logic [3:0] d;
    logic [6:0] two;

    assign in_stall = job_full;
    assign take = in_valid && !job_full;
    assign dig = (text_char >= 8'h30) && (text_char <= 8'h39);
    assign d = dig ? 4'(text_char - 8'h30) : 4'd0;

    // parse step for one character
    always_comb
    begin
        pos_next = pos_reg; phase_next = phase_reg; err_next = err_reg;
        year_next = year_reg; mon_next = mon_reg; day_next = day_reg;
        hr_next = hr_reg; min_next = min_reg; sec_next = sec_reg;
        frac_next = frac_reg; fd_next = fd_reg; zn_next = zn_reg;
        zh_next = zh_reg; zm_next = zm_reg;
        two = 7'd0;
        if (!err_reg)
        begin
            case (phase_reg)
                PH_FIXED:
                begin
                    if (pos_reg == 5'd4 || pos_reg == 5'd7)
                    begin
                        if (text_char != "-") err_next = 1'b1;
                    end
                    else if (pos_reg == 5'd10)
                    begin
                        if (text_char != "T" && text_char != "t") err_next = 1'b1;
                    end
                    else if (pos_reg == 5'd13 || pos_reg == 5'd16)
                    begin
                        if (text_char != ":") err_next = 1'b1;
                    end
                    else if (!dig) err_next = 1'b1;
                    else if (pos_reg <= 5'd3) year_next = 14'(year_reg * 14'd10 + 14'(d));
                    else if (pos_reg <= 5'd6)
                    begin
                        two = 7'(mon_reg) * 7'd10 + 7'(d);
                        if (pos_reg != 5'd6) mon_next = d;
                        else if (two > 7'd12) err_next = 1'b1;
                        else mon_next = 4'(two);
                    end
                    else if (pos_reg <= 5'd9)
                    begin
                        two = 7'(day_reg) * 7'd10 + 7'(d);
                        if (pos_reg != 5'd9) day_next = 5'(d);
                        else if (two > 7'd31) err_next = 1'b1;
                        else day_next = 5'(two);
                    end
                    else if (pos_reg <= 5'd12)
                    begin
                        two = 7'(hr_reg) * 7'd10 + 7'(d);
                        if (pos_reg != 5'd12) hr_next = 5'(d);
                        else if (two > 7'd23) err_next = 1'b1;
                        else hr_next = 5'(two);
                    end
                    else if (pos_reg <= 5'd15)
                    begin
                        two = 7'(min_reg) * 7'd10 + 7'(d);
                        if (pos_reg != 5'd15) min_next = 6'(d);
                        else if (two > 7'd59) err_next = 1'b1;
                        else min_next = 6'(two);
                    end
                    else
                    begin
                        two = 7'(sec_reg) * 7'd10 + 7'(d);
                        if (pos_reg != 5'd18) sec_next = 6'(d);
                        else if (two > 7'd60) err_next = 1'b1;
                        else sec_next = 6'(two);
                    end
                    if (pos_reg >= 5'd18)
                    begin
                        phase_next = PH_AFTER_SEC;
                        pos_next = 5'd0;
                    end
                    else pos_next = pos_reg + 5'd1;
                end
                PH_AFTER_SEC, PH_FRAC:
                begin
                    if (phase_reg == PH_AFTER_SEC && text_char == ".") phase_next = PH_FRAC;
                    else if (phase_reg == PH_FRAC && dig)
                    begin
                        if (fd_reg != 2'd3)
                        begin
                            frac_next = 10'(frac_reg * 10'd10 + 10'(d));
                            fd_next = fd_reg + 2'd1;
                        end
                    end
                    else if (phase_reg == PH_FRAC && fd_reg == 2'd0) err_next = 1'b1;
                    else if (text_char == "Z" || text_char == "z") phase_next = PH_DONE;
                    else if (text_char == "+" || text_char == "-")
                    begin
                        zn_next = (text_char == "-");
                        phase_next = PH_OFFSET;
                        pos_next = 5'd0;
                    end
                    else err_next = 1'b1;
                end
                PH_OFFSET:
                begin
                    if (pos_reg == 5'd2)
                    begin
                        if (text_char != ":") err_next = 1'b1;
                    end
                    else if (!dig) err_next = 1'b1;
                    else if (pos_reg <= 5'd1)
                    begin
                        two = 7'(zh_reg) * 7'd10 + 7'(d);
                        if (pos_reg != 5'd1) zh_next = 5'(d);
                        else if (two > 7'd23) err_next = 1'b1;
                        else zh_next = 5'(two);
                    end
                    else
                    begin
                        two = 7'(zm_reg) * 7'd10 + 7'(d);
                        if (pos_reg != 5'd4) zm_next = 6'(d);
                        else if (two > 7'd59) err_next = 1'b1;
                        else zm_next = 6'(two);
                    end
                    if (pos_reg >= 5'd4) phase_next = PH_DONE;
                    else pos_next = pos_reg + 5'd1;
                end
                default: err_next = 1'b1;
            endcase
        end
    end

    // transaction to the back end on the last character
    always_comb
    begin
        job_valid = take && last_char;
        job.ok = !err_next && phase_next == PH_DONE && year_next != 14'd0
            && year_next <= 14'd9999 && mon_next != 4'd0 && mon_next <= 4'd12
            && day_next != 5'd0 && day_next <= month_len(year_next, mon_next);
        job.year = year_next; job.month = mon_next; job.day = day_next;
        job.hour = hr_next; job.minute = min_next; job.second = sec_next;
        job.frac = (fd_next == 2'd1) ? 10'(frac_next * 10'd100)
                 : (fd_next == 2'd2) ? 10'(frac_next * 10'd10) : frac_next;
        job.zone_neg = zn_next; job.zone_hour = zh_next; job.zone_minute = zm_next;
        job.now = now_millis;
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; phase_reg <= PH_FIXED; err_reg <= 1'b0;
            year_reg <= '0; mon_reg <= '0; day_reg <= '0; hr_reg <= '0;
            min_reg <= '0; sec_reg <= '0; frac_reg <= '0; fd_reg <= '0;
            zn_reg <= 1'b0; zh_reg <= '0; zm_reg <= '0;
        end
        else if (take)
        begin
            if (last_char)
            begin
                pos_reg <= '0; phase_reg <= PH_FIXED; err_reg <= 1'b0;
                year_reg <= '0; mon_reg <= '0; day_reg <= '0; hr_reg <= '0;
                min_reg <= '0; sec_reg <= '0; frac_reg <= '0; fd_reg <= '0;
                zn_reg <= 1'b0; zh_reg <= '0; zm_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_next; phase_reg <= phase_next; err_reg <= err_next;
                year_reg <= year_next; mon_reg <= mon_next; day_reg <= day_next;
                hr_reg <= hr_next; min_reg <= min_next; sec_reg <= sec_next;
                frac_reg <= frac_next; fd_reg <= fd_next; zn_reg <= zn_next;
                zh_reg <= zh_next; zm_reg <= zm_next;
            end
        end
    end
endmodule
`default_nettype wire

>>> src/rdp_queue.sv
// short job queue between front and back end
`default_nettype none
module rdp_queue #(
    parameter int Depth = rdp_pkg::QueueDepth
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire rdp_pkg::rdp_job_t push_job,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output rdp_pkg::rdp_job_t      head_job
);
    import rdp_pkg::*;

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    rdp_job_t       mem_reg [Depth];
    logic [AW-1:0]  wr_reg, rd_reg;
    logic [AW:0]    cnt_reg;

    assign full = (cnt_reg == (AW+1)'(Depth));
    assign not_empty = (cnt_reg != '0);
    assign head_job = mem_reg[rd_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= push_job;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0; rd_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= (wr_reg == AW'(Depth-1)) ? '0 : wr_reg + 1'b1;
            if (pop) rd_reg <= (rd_reg == AW'(Depth-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

>>> src/rdp_back.sv
// back end: days from civil, millisecond conversion and deadline compare
`default_nettype none
module rdp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_avail,
    input  wire rdp_pkg::rdp_job_t job,
    output logic                   job_pop,
    input  wire logic signed [rdp_pkg::MillisW-1:0] min_trusted,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   parse_ok,
    output logic signed [rdp_pkg::UtcW-1:0] instant_millis,
    output logic [rdp_pkg::StateW-1:0] deadline_state
);
    import rdp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_A = 3'd1, S_B = 3'd2, S_C = 3'd3,
                           S_D = 3'd4, S_E = 3'd5, S_OUT = 3'd6;

    logic [2:0]  st_reg, st_next;
    rdp_job_t    j_reg;
    logic [5:0]  era_reg;
    logic [8:0]  yoe_reg;
    logic [8:0]  doy_reg;
    logic signed [23:0] days_reg;
    logic signed [18:0] tod_reg;    // seconds of day minus offset
    logic signed [39:0] secs_reg;
    logic signed [UtcW:0] ms_reg;

    logic [13:0] yy;
    logic [27:0] era_prod;
    logic [5:0]  era;
    logic [8:0]  yoe;
    logic [3:0]  mp;
    logic [8:0]  mstart;
    logic [8:0]  doy;
    logic [1:0]  cent;
    logic [17:0] doe;
    logic [16:0] off;

    // calendar split: era by reciprocal multiplication, month start from a table
    always_comb
    begin
        yy       = j_reg.year - ((j_reg.month <= 4'd2) ? 14'd1 : 14'd0);
        era_prod = 28'(yy) * 28'd10486;
        era      = era_prod[27:22];
        yoe      = 9'(yy - 14'(era) * 14'd400);
        mp       = (j_reg.month > 4'd2) ? j_reg.month - 4'd3 : j_reg.month + 4'd9;
        case (mp)
            4'd0:  mstart = 9'd0;
            4'd1:  mstart = 9'd31;
            4'd2:  mstart = 9'd61;
            4'd3:  mstart = 9'd92;
            4'd4:  mstart = 9'd122;
            4'd5:  mstart = 9'd153;
            4'd6:  mstart = 9'd184;
            4'd7:  mstart = 9'd214;
            4'd8:  mstart = 9'd245;
            4'd9:  mstart = 9'd275;
            4'd10: mstart = 9'd306;
            4'd11: mstart = 9'd337;
            default: mstart = 9'd0;
        endcase
        doy = mstart + 9'(j_reg.day) - 9'd1;
        off = 17'((12'(j_reg.zone_hour) * 12'd60 + 12'(j_reg.zone_minute)) * 17'd60);
        // centuries within the era
        cent = (yoe_reg >= 9'd300) ? 2'd3 : (yoe_reg >= 9'd200) ? 2'd2
             : (yoe_reg >= 9'd100) ? 2'd1 : 2'd0;
        doe = 18'(yoe_reg) * 18'd365 + 18'(yoe_reg >> 2) - 18'(cent) + 18'(doy_reg);
    end

    assign job_pop = (st_reg == S_IDLE) && job_avail;
    assign out_valid = (st_reg == S_OUT);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE: if (job_avail) st_next = S_A;
            S_A: st_next = S_B;
            S_B: st_next = S_C;
            S_C: st_next = S_D;
            S_D: st_next = S_E;
            S_E: st_next = S_OUT;
            S_OUT: if (!out_stall) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) st_reg <= S_IDLE;
        else st_reg <= st_next;
    end

    // datapath steps
    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_IDLE: if (job_avail) j_reg <= job;
            S_A:
            begin
                era_reg <= era;
                yoe_reg <= yoe;
                doy_reg <= doy;
                tod_reg <= 19'(j_reg.hour) * 19'd3600 + 19'(j_reg.minute) * 19'd60
                    + 19'(j_reg.second) + (j_reg.zone_neg ? 19'(off) : -19'(off));
            end
            S_B: days_reg <= 24'(era_reg) * 24'd146097 + 24'(doe) - 24'd719468;
            S_C: secs_reg <= 40'(days_reg) * 40'sd86400 + 40'(tod_reg);
            S_D: ms_reg <= (UtcW+1)'(secs_reg) * (UtcW+1)'(1000) + (UtcW+1)'(j_reg.frac);
            S_E:
            begin
                parse_ok <= j_reg.ok;
                instant_millis <= j_reg.ok ? UtcW'(ms_reg) : '0;
                if (!j_reg.ok || j_reg.now < min_trusted) deadline_state <= DL_UNKNOWN;
                else if (j_reg.now >= 64'(ms_reg)) deadline_state <= DL_EXPIRED;
                else deadline_state <= DL_LIVE;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> src/rfc3339_deadline_parser.sv
// top level of the timestamp parser with deadline check
`default_nettype none
// Accepts one timestamp character per cycle; the front end checks layout and
// ranges as characters stream in. On the last character a job enters a
// two-entry queue, and the back end works on one job at a time: it takes the
// job from the queue, computes in turn the calendar split, days, seconds,
// milliseconds and compare, and then presents the result until the output is
// not stalled. Strings that arrive faster than jobs finish can therefore fill
// the queue, and the input stalls on any character while the queue is full.
module rfc3339_deadline_parser #(
    parameter int QueueDepth = rdp_pkg::QueueDepth
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic signed [rdp_pkg::MillisW-1:0] cfg_data,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire logic [rdp_pkg::CharW-1:0] text_char,
    input  wire logic last_char,
    input  wire logic signed [rdp_pkg::MillisW-1:0] now_millis,
    output logic      out_valid,
    input  wire logic out_stall,
    output logic      parse_ok,
    output logic signed [rdp_pkg::UtcW-1:0] instant_millis,
    output logic [rdp_pkg::StateW-1:0] deadline_state
);
    import rdp_pkg::*;

    logic signed [MillisW-1:0] min_trusted_reg;
    logic     job_valid, q_full, q_ne, q_pop;
    rdp_job_t job, head;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) min_trusted_reg <= '0;
        else if (cfg_we) min_trusted_reg <= cfg_data;
    end

    rdp_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .text_char, .last_char, .now_millis,
        .job_valid, .job, .job_full(q_full)
    );

    rdp_queue #(.Depth(QueueDepth)) u_queue (
        .clk, .rst_n, .push(job_valid), .push_job(job), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .head_job(head)
    );

    rdp_back u_back (
        .clk, .rst_n, .job_avail(q_ne), .job(head), .job_pop(q_pop),
        .min_trusted(min_trusted_reg), .out_valid, .out_stall,
        .parse_ok, .instant_millis, .deadline_state
    );
endmodule
`default_nettype wire

>>> tb/sv/rfc3339_deadline_parser_test.sv
// self-checking testbench for the rfc3339 timestamp parser with deadline check
`timescale 1ns / 100ps
module rfc3339_deadline_parser_test;
    import rdp_pkg::*;

    localparam int WatchdogLimit = 4000;
    localparam int DrainCycles   = 20;
    localparam int LongHold      = 250;

    typedef struct {
        logic [7:0]         ch;
        logic               last;
        logic signed [63:0] now;
    } char_item_t;

    typedef struct {
        logic               ok;
        logic [48:0]        millis;
        logic [1:0]         state;
    } deadline_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic signed [63:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [7:0] text_char;
    logic last_char;
    logic signed [63:0] now_millis;
    logic out_valid;
    logic out_stall;
    logic parse_ok;
    logic signed [48:0] instant_millis;
    logic [1:0] deadline_state;

    char_item_t       pending_chars[$];
    deadline_result_t expected_results[$];

    // parser state mirrored by the predictor
    logic signed [63:0] trusted_floor;
    logic [4:0]  pos;
    logic [2:0]  phase;
    logic        err;
    logic [13:0] year_v;
    logic [3:0]  month_v;
    logic [4:0]  day_v;
    logic [4:0]  hour_v;
    logic [5:0]  minute_v;
    logic [5:0]  second_v;
    logic [9:0]  frac_v;
    logic [1:0]  frac_cnt;
    logic        zone_neg;
    logic [4:0]  zone_hour_v;
    logic [5:0]  zone_minute_v;

    int errors;
    int items_sent;
    int strings_sent;
    int results_seen;
    int ok_seen;
    int live_seen;
    int expired_seen;
    int unknown_seen;
    int stall_mode;
    bit hold_req;
    bit hold_taken;
    int hold_cnt;
    int stall_tick;
    int burst_left;
    int gap_left;
    int idle_cycles;

    rfc3339_deadline_parser i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .text_char      (text_char),
        .last_char      (last_char),
        .now_millis     (now_millis),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .parse_ok       (parse_ok),
        .instant_millis (instant_millis),
        .deadline_state (deadline_state)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic clear_parser();
        pos = '0; phase = PH_FIXED; err = 1'b0;
        year_v = '0; month_v = '0; day_v = '0; hour_v = '0; minute_v = '0;
        second_v = '0; frac_v = '0; frac_cnt = '0; zone_neg = 1'b0;
        zone_hour_v = '0; zone_minute_v = '0;
    endtask

    // one digit of a two-digit field; a units digit pushing past max flags an error
    function automatic int field_digit(int acc, int d, bit units, int max, inout logic e);
        int v;
        begin
            if (!units)
                return d;
            v = acc * 10 + d;
            if (v > max)
            begin
                e = 1'b1;
                return acc;
            end
            return v;
        end
    endfunction

    function automatic int days_in_month(int y, int m);
        bit leap;
        begin
            leap = (y % 4 == 0) && (y % 100 != 0 || y % 400 == 0);
            if (m == 2)
                return leap ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        end
    endfunction

    function automatic longint days_since_epoch(int y, int m, int d);
        longint yy, era, yoe, mp, doy, doe;
        begin
            yy  = y - ((m <= 2) ? 1 : 0);
            era = yy / 400;
            yoe = yy - era * 400;
            mp  = (m > 2) ? m - 3 : m + 9;
            doy = (153 * mp + 2) / 5 + d - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            return era * 146097 + doe - 719468;
        end
    endfunction

    // zone letter or offset sign
    task automatic zone_begin(logic [7:0] c);
        if (c == "Z" || c == "z")
            phase = PH_DONE;
        else if (c == "+" || c == "-")
        begin
            zone_neg = (c == "-");
            phase = PH_OFFSET;
            pos = '0;
        end
        else
            err = 1'b1;
    endtask

    // advance the parse by one character
    task automatic parse_char(logic [7:0] c);
        int p;
        bit dig;
        int d;
        p = pos;
        dig = (c >= "0" && c <= "9");
        d = dig ? c - "0" : 0;
        case (phase)
            PH_FIXED:
            begin
                if (p == 4 || p == 7)
                begin
                    if (c != "-") err = 1'b1;
                end
                else if (p == 10)
                begin
                    if (c != "T" && c != "t") err = 1'b1;
                end
                else if (p == 13 || p == 16)
                begin
                    if (c != ":") err = 1'b1;
                end
                else if (!dig)
                    err = 1'b1;
                else if (p <= 3)
                    year_v = 14'(year_v * 10 + d);
                else if (p <= 6)
                    month_v = 4'(field_digit(month_v, d, p == 6, 12, err));
                else if (p <= 9)
                    day_v = 5'(field_digit(day_v, d, p == 9, 31, err));
                else if (p <= 12)
                    hour_v = 5'(field_digit(hour_v, d, p == 12, 23, err));
                else if (p <= 15)
                    minute_v = 6'(field_digit(minute_v, d, p == 15, 59, err));
                else
                    second_v = 6'(field_digit(second_v, d, p == 18, 60, err));
                if (p >= 18)
                begin
                    phase = PH_AFTER_SEC;
                    pos = '0;
                end
                else
                    pos = 5'(p + 1);
            end
            PH_AFTER_SEC:
            begin
                if (c == ".")
                    phase = PH_FRAC;
                else
                    zone_begin(c);
            end
            PH_FRAC:
            begin
                if (dig)
                begin
                    if (frac_cnt < 3)
                    begin
                        frac_v = 10'(frac_v * 10 + d);
                        frac_cnt = frac_cnt + 2'd1;
                    end
                end
                else if (frac_cnt == 0)
                    err = 1'b1;
                else
                    zone_begin(c);
            end
            PH_OFFSET:
            begin
                if (p == 2)
                begin
                    if (c != ":") err = 1'b1;
                end
                else if (!dig)
                    err = 1'b1;
                else if (p <= 1)
                    zone_hour_v = 5'(field_digit(zone_hour_v, d, p == 1, 23, err));
                else
                    zone_minute_v = 6'(field_digit(zone_minute_v, d, p == 4, 59, err));
                if (p >= 4)
                    phase = PH_DONE;
                else
                    pos = 5'(p + 1);
            end
            default:
                err = 1'b1;
        endcase
    endtask

    // predict the deadline result caused by one accepted character
    task automatic predict_deadline(char_item_t it);
        deadline_result_t r;
        longint secs, off, ms;
        int frac;
        if (!err)
            parse_char(it.ch);
        if (it.last)
        begin
            r.ok = !err && phase == PH_DONE && year_v >= 1 && year_v <= 9999 &&
                   month_v >= 1 && month_v <= 12 && day_v >= 1 &&
                   day_v <= days_in_month(year_v, month_v);
            r.millis = '0;
            r.state = DL_UNKNOWN;
            if (r.ok)
            begin
                frac = frac_v;
                if (frac_cnt == 1) frac = frac * 100;
                else if (frac_cnt == 2) frac = frac * 10;
                off = (longint'(zone_hour_v) * 60 + zone_minute_v) * 60;
                if (zone_neg) off = -off;
                secs = days_since_epoch(year_v, month_v, day_v) * 86400 +
                       longint'(hour_v) * 3600 + longint'(minute_v) * 60 +
                       longint'(second_v) - off;
                ms = secs * 1000 + frac;
                r.millis = ms[48:0];
                if (it.now >= trusted_floor)
                    r.state = (it.now >= ms) ? DL_EXPIRED : DL_LIVE;
            end
            expected_results.push_back(r);
            clear_parser();
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        if (errors <= 40)
            $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    endtask

    function automatic logic signed [63:0] random_now();
        logic [63:0] v;
        begin
            if ($urandom_range(0, 2) == 0)
                v = {$urandom, $urandom};
            else
            begin
                v[48:0] = {$urandom, $urandom};
                v[63:49] = {15{v[48]}};
            end
            return v;
        end
    endfunction

    // queue a string, one transaction per character, last flag on the final one
    task automatic push_text(string s);
        char_item_t it;
        for (int i = 0; i < s.len(); i++)
        begin
            it.ch = s[i];
            it.last = (i == s.len() - 1);
            it.now = random_now();
            pending_chars.push_back(it);
        end
        items_sent += s.len();
        strings_sent++;
    endtask

    // mostly well-formed timestamp with random content
    function automatic string random_stamp();
        string s, frac, zone;
        int y, m, d, nd;
        begin
            y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9999) : $urandom_range(1, 9999);
            if ($urandom_range(0, 3) == 0)
                y = ($urandom_range(0, 1) ? 2000 : 1900) + 4 * $urandom_range(0, 30);
            m = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 13) : $urandom_range(1, 12);
            d = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 32)
              : $urandom_range(1, (m >= 1 && m <= 12) ? days_in_month(y, m) : 31);
            if ($urandom_range(0, 5) == 0 && m >= 1 && m <= 12)
                d = days_in_month(y, m) + $urandom_range(0, 1);
            s = $sformatf("%04d-%02d-%02d%s%02d:%02d:%02d", y, m, d,
                          $urandom_range(0, 1) ? "T" : "t",
                          $urandom_range(0, 24), $urandom_range(0, 60), $urandom_range(0, 61));
            frac = "";
            nd = $urandom_range(0, 5);
            if (nd > 0 || $urandom_range(0, 9) == 0)
            begin
                frac = ".";
                for (int i = 0; i < nd; i++)
                    frac = {frac, $sformatf("%0d", $urandom_range(0, 9))};
            end
            case ($urandom_range(0, 3))
                0: zone = "Z";
                1: zone = "z";
                default: zone = $sformatf("%s%02d:%02d", $urandom_range(0, 1) ? "+" : "-",
                                          $urandom_range(0, 24), $urandom_range(0, 60));
            endcase
            return {s, frac, zone};
        end
    endfunction

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_floor(logic signed [63:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        trusted_floor = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // driver: bursts of characters with random gaps, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            text_char <= '0;
            last_char <= 1'b0;
            now_millis <= '0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_deadline(pending_chars.pop_front());
            end
            if (in_valid && in_stall)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_chars.size() != 0)
            begin
                in_valid <= 1'b1;
                text_char <= pending_chars[0].ch;
                last_char <= pending_chars[0].last;
                now_millis <= pending_chars[0].now;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: stall pattern and comparison with the oldest expected result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_taken <= 1'b0;
            hold_cnt = 0;
            stall_tick = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result count", results_seen, 0);
                else
                begin
                    if (parse_ok !== expected_results[0].ok)
                        report_mismatch("parse_ok", parse_ok, expected_results[0].ok);
                    if (instant_millis !== expected_results[0].millis)
                        report_mismatch("instant_millis", instant_millis,
                                        $signed(expected_results[0].millis));
                    if (deadline_state !== expected_results[0].state)
                        report_mismatch("deadline_state", deadline_state,
                                        expected_results[0].state);
                    ok_seen += expected_results[0].ok;
                    case (expected_results[0].state)
                        DL_LIVE: live_seen++;
                        DL_EXPIRED: expired_seen++;
                        default: unknown_seen++;
                    endcase
                    void'(expected_results.pop_front());
                end
            end
            stall_tick++;
            if (hold_req && !hold_taken)
            begin
                hold_taken <= 1'b1;
                hold_cnt = LongHold;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else
                case (stall_mode)
                    1: out_stall <= ($urandom_range(0, 99) < 30);
                    2: out_stall <= (stall_tick % 7 < 3);
                    3: out_stall <= ($urandom_range(0, 99) < 75);
                    default: out_stall <= 1'b0;
                endcase
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        logic signed [63:0] floors[5];
        string s;
        int pos_m;
        floors[0] = 64'sd0;
        floors[1] = 64'sh8000_0000_0000_0000;
        floors[2] = 64'sh7FFF_FFFF_FFFF_FFFF;
        floors[3] = {$urandom, $urandom} >>> 15;
        floors[4] = -64'sd1;
        errors = 0; items_sent = 0; strings_sent = 0; results_seen = 0;
        ok_seen = 0; live_seen = 0; expired_seen = 0; unknown_seen = 0;
        stall_mode = 0; hold_req = 0; idle_cycles = 0;
        trusted_floor = 64'sd0;
        clear_parser();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and each corner of the layout
        push_text("0001-01-01T00:00:00Z");
        push_text("9999-12-31T23:59:60.999-23:59");
        push_text("9999-12-31t23:59:59.999+00:00");
        push_text("0001-01-01T00:00:00+23:59");
        push_text("2000-02-29t12:30:45.1+05:30");
        push_text("1900-02-29T00:00:00Z");
        push_text("2024-13-01T00:00:00Z");
        push_text("2023-04-31T00:00:00Z");
        push_text("2023-01-32T00:00:00Z");
        push_text("0000-06-15T10:00:00Z");
        push_text("2024-01-01T24:00:00Z");
        push_text("2024-01-01T00:60:00Z");
        push_text("2024-01-01T00:00:61Z");
        push_text("2024-01-01T00:00:00+24:00");
        push_text("2024-01-01T00:00:00-00:60");
        push_text("2024-01-01T00:00:00.Z");
        push_text("2024-01-01T00:00:00.12345z");
        push_text("2024-01-01T00:00:00.12Z");
        push_text("2024-01-01T00:00:00Z1");
        push_text("2024-01-01T00:00:00+01:00:");
        push_text("2024-01");
        push_text({"2024-01-01X00:00:00", 8'hFF});
        push_text({8'h80, 8'h7F, "Z"});

        // random phases, one per trusted floor setting
        for (int ph = 0; ph < 5; ph++)
        begin
            wait_idle();
            write_floor(floors[ph]);
            stall_mode = ph % 4;
            if (ph == 2)
                hold_req = 1'b1;
            for (int n = 0; n < 2; n++)
            begin
                case ($urandom_range(0, 9))
                    0: begin
                        // noise bytes, sometimes short strings that pile up in the queue before the back end
                        s = "";
                        for (int i = $urandom_range(1, 6); i > 0; i--)
                            s = {s, string'(8'($urandom_range(0, 255)))};
                        push_text(s);
                    end
                    1: begin
                        s = random_stamp();
                        push_text(s.substr(0, $urandom_range(0, s.len() - 2)));
                    end
                    2: begin
                        s = random_stamp();
                        pos_m = $urandom_range(0, s.len() - 1);
                        s[pos_m] = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(48, 58));
                        push_text(s);
                    end
                    default: push_text(random_stamp());
                endcase
            end
            if (ph == 2)
                for (int n = 0; n < 20; n++)
                    push_text("Z");
        end
        while (items_sent < 650)
            push_text(random_stamp());

        // drain
        wait_idle();
        if (expected_results.size() != 0)
            report_mismatch("results still outstanding", 0, expected_results.size());
        $display("covered %0d characters in %0d strings, %0d results, %0d parsed valid",
                 items_sent, strings_sent, results_seen, ok_seen);
        $display("deadline states: %0d live, %0d expired, %0d unknown, %0d floor settings",
                 live_seen, expired_seen, unknown_seen, 5);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
